### sv/hbo_pkg.sv
// Shared types and constants for the histogram binning unit.
package hbo_pkg;

  localparam int DATA_W     = 32;
  localparam int SEL_W      = 8;
  localparam int RESULT_W   = 32;
  localparam int WIDTH_W    = 31;
  localparam int BINS_W     = 9;
  localparam int CLASS_W    = 2;
  localparam int ADDR_W     = 4;
  localparam int REG_IDX_W  = 2;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [REG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BIN_WIDTH  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_BINS_USED  = 2'd3;

  localparam logic [DATA_W-1:0]  RANGE_LOW_RST  = 32'd0;
  localparam logic [DATA_W-1:0]  RANGE_HIGH_RST = 32'd16777216;
  localparam logic [WIDTH_W-1:0] BIN_WIDTH_RST  = 31'd65536;
  localparam logic [BINS_W-1:0]  BINS_USED_RST  = 9'd256;

  typedef enum logic [CLASS_W-1:0] {
    CLS_BINNED = 2'd0,
    CLS_BELOW  = 2'd1,
    CLS_ABOVE  = 2'd2,
    CLS_READ   = 2'd3
  } sample_class_e;

  typedef struct packed {
    logic [DATA_W-1:0]  range_low;
    logic [DATA_W-1:0]  range_high;
    logic [WIDTH_W-1:0] width_of_bin;
    logic [BINS_W-1:0]  bins_in_use;
  } cfg_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic bump;
    logic div_first;
    logic div_step;
    logic rd_bin;
    logic wr_bin;
    logic rd_sel;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic          clr_last;
    sample_class_e cls;
  } status_t;

endpackage

### sv/hbo_regs.sv
// APB configuration registers of the histogram binning unit.
module hbo_regs
  import hbo_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t                 cfg_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_low    <= RANGE_LOW_RST;
      cfg_q.range_high   <= RANGE_HIGH_RST;
      cfg_q.width_of_bin <= BIN_WIDTH_RST;
      cfg_q.bins_in_use  <= BINS_USED_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RANGE_LOW:  cfg_q.range_low    <= pwdata;
        REG_RANGE_HIGH: cfg_q.range_high   <= pwdata;
        REG_BIN_WIDTH:  cfg_q.width_of_bin <= pwdata[WIDTH_W-1:0];
        REG_BINS_USED:  cfg_q.bins_in_use  <= pwdata[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RANGE_LOW:  prdata = cfg_q.range_low;
      REG_RANGE_HIGH: prdata = cfg_q.range_high;
      REG_BIN_WIDTH:  prdata = DATA_W'(cfg_q.width_of_bin);
      REG_BINS_USED:  prdata = DATA_W'(cfg_q.bins_in_use);
      default:        prdata = '0;
    endcase
  end

endmodule

### sv/hbo_datapath.sv
// Datapath: classifier, restoring divider, bin memory, outlier counters, result registers.
module hbo_datapath
  import hbo_pkg::*;
#(
  parameter int MAX_BINS    = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic                kind_i,
  input  logic [DATA_W-1:0]   sample_i,
  input  logic [SEL_W-1:0]    bin_select_i,
  output logic                valid_o,
  output logic [RESULT_W-1:0] bin_total_o,
  output logic [RESULT_W-1:0] below_total_o,
  output logic [RESULT_W-1:0] above_total_o,
  output logic [CLASS_W-1:0]  sample_class_o,
  output logic [SEL_W-1:0]    sample_bin_o
);

  localparam int BIN_W = $clog2(MAX_BINS);
  localparam int NUM_W = $clog2(MAX_BINS + 1);

  logic [COUNT_WIDTH-1:0] bins_q [MAX_BINS];
  logic [COUNT_WIDTH-1:0] rdata_q;
  logic [COUNT_WIDTH-1:0] below_q, above_q;
  logic [BIN_W-1:0]       clr_addr_q;
  logic [BIN_W-1:0]       bin_idx_q;
  logic [SEL_W-1:0]       sel_q;
  sample_class_e          cls_q;
  sample_class_e          cls_d;
  logic [DATA_W-1:0]      quo_q, quo_d;
  logic [DATA_W-1:0]      rem_q, rem_d;
  logic [DATA_W:0]        diff;
  logic [DATA_W:0]        shifted;
  logic [DATA_W:0]        divisor;
  logic                   fits;
  logic [NUM_W-1:0]       n_eff;
  logic [BIN_W-1:0]       last_bin;
  logic [BIN_W-1:0]       bin_calc;
  logic                   mem_we, mem_re;
  logic [BIN_W-1:0]       waddr, raddr;
  logic [COUNT_WIDTH-1:0] wdata;
  logic                   sel_ok;
  logic [63:0]            rd_wide, below_wide, above_wide;
  logic                   valid_q;
  logic [RESULT_W-1:0]    bin_total_q, below_total_q, above_total_q;
  logic [CLASS_W-1:0]     class_q;
  logic [SEL_W-1:0]       sample_bin_q;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (c == '1) ? c : c + COUNT_WIDTH'(1);
  endfunction

  always_comb begin
    if (kind_i) begin
      cls_d = CLS_READ;
    end else if ($signed(sample_i) < $signed(cfg_i.range_low)) begin
      cls_d = CLS_BELOW;
    end else if ($signed(sample_i) >= $signed(cfg_i.range_high)) begin
      cls_d = CLS_ABOVE;
    end else begin
      cls_d = CLS_BINNED;
    end
  end

  assign diff = {sample_i[DATA_W-1], sample_i} - {cfg_i.range_low[DATA_W-1], cfg_i.range_low};

  // restoring divide, one quotient bit a step
  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign divisor = (DATA_W + 1)'(cfg_i.width_of_bin);
  assign fits    = shifted >= divisor;
  assign rem_d   = fits ? DATA_W'(shifted - divisor) : DATA_W'(shifted);
  assign quo_d   = {quo_q[DATA_W-2:0], fits};

  always_comb begin
    if (cfg_i.bins_in_use == '0) begin
      n_eff = NUM_W'(1);
    end else if (32'(cfg_i.bins_in_use) > 32'(MAX_BINS)) begin
      n_eff = NUM_W'(MAX_BINS);
    end else begin
      n_eff = NUM_W'(cfg_i.bins_in_use);
    end
  end

  assign last_bin = BIN_W'(n_eff - NUM_W'(1));
  assign bin_calc = (quo_q >= DATA_W'(n_eff)) ? last_bin : BIN_W'(quo_q);

  assign mem_we = cmd_i.clr_step || cmd_i.wr_bin;
  assign mem_re = cmd_i.rd_bin || cmd_i.rd_sel;
  assign waddr  = cmd_i.clr_step ? clr_addr_q : bin_idx_q;
  assign wdata  = cmd_i.clr_step ? '0 : sat_inc(rdata_q);
  assign raddr  = cmd_i.rd_bin ? bin_calc : BIN_W'(sel_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bins_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= bins_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      below_q    <= '0;
      above_q    <= '0;
      valid_q    <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + BIN_W'(1);
      end
      if (cmd_i.bump && cls_q == CLS_BELOW) begin
        below_q <= sat_inc(below_q);
      end
      if (cmd_i.bump && cls_q == CLS_ABOVE) begin
        above_q <= sat_inc(above_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sel_q <= bin_select_i;
      cls_q <= cls_d;
      quo_q <= diff[DATA_W-1:0];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (cmd_i.rd_bin) begin
      bin_idx_q <= bin_calc;
    end
  end

  assign sel_ok     = 32'(sel_q) < 32'(MAX_BINS);
  assign rd_wide    = 64'(rdata_q);
  assign below_wide = 64'(below_q);
  assign above_wide = 64'(above_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      bin_total_q   <= sel_ok ? rd_wide[RESULT_W-1:0] : '0;
      below_total_q <= below_wide[RESULT_W-1:0];
      above_total_q <= above_wide[RESULT_W-1:0];
      class_q       <= cls_q;
      sample_bin_q  <= (cls_q == CLS_BINNED) ? SEL_W'(bin_idx_q) : '0;
    end
  end

  assign status_o.clr_last = clr_addr_q == BIN_W'(MAX_BINS - 1);
  assign status_o.cls      = cls_q;

  assign valid_o        = valid_q;
  assign bin_total_o    = bin_total_q;
  assign below_total_o  = below_total_q;
  assign above_total_o  = above_total_q;
  assign sample_class_o = class_q;
  assign sample_bin_o   = sample_bin_q;

endmodule

### sv/hbo_ctrl.sv
// Controller state machine sequencing clear, classify, divide, update and report.
module hbo_ctrl
  import hbo_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CLASS,
    S_DIV,
    S_RD_BIN,
    S_WR_BIN,
    S_RD_SEL,
    S_OUT
  } state_e;

  state_e               state_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (status_i.clr_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state_q <= S_CLASS;
          end
        end
        S_CLASS: begin
          cnt_q <= '0;
          if (status_i.cls == CLS_BINNED) begin
            state_q <= S_DIV;
          end else begin
            state_q <= S_RD_SEL;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + DIV_CNT_W'(1);
          if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_q <= S_RD_BIN;
          end
        end
        S_RD_BIN: state_q <= S_WR_BIN;
        S_WR_BIN: state_q <= S_RD_SEL;
        S_RD_SEL: state_q <= S_OUT;
        S_OUT:    state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.clr_step  = state_q == S_CLEAR;
    cmd_o.load      = state_q == S_IDLE && start;
    cmd_o.bump      = state_q == S_CLASS;
    cmd_o.div_first = state_q == S_DIV && cnt_q == '0;
    cmd_o.div_step  = state_q == S_DIV;
    cmd_o.rd_bin    = state_q == S_RD_BIN;
    cmd_o.wr_bin    = state_q == S_WR_BIN;
    cmd_o.rd_sel    = state_q == S_RD_SEL;
    cmd_o.emit      = state_q == S_OUT;
  end

  assign busy = state_q != S_IDLE;

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_first |-> ##31 (state_q == S_DIV) ##1 (state_q == S_RD_BIN))
    else $error("divider ran the wrong number of steps");

endmodule

### sv/histogram_binning_with_outliers_unit.sv
// Top level of the histogram binning unit with outlier counters.
// A request is taken when start is high and busy is low. A read request or an
// out-of-range sample is classified, reads the selected bin and is reported;
// a binned sample is also divided by the 32-step restoring divider by the bin
// width, followed by the read-modify-write of the bin memory. Busy stays high
// until the result strobe, so no new request is taken before the last is done.
// Each result is shown for one cycle on valid_o and must be taken then.
// After reset the bin memory is cleared one entry a cycle, with busy high
// until the clear is done; configuration writes are taken throughout.
module histogram_binning_with_outliers_unit
  import hbo_pkg::*;
#(
  parameter int MAX_BINS    = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                start,
  output logic                busy,
  input  logic                kind_i,
  input  logic [DATA_W-1:0]   sample_i,
  input  logic [SEL_W-1:0]    bin_select_i,
  output logic                valid_o,
  output logic [RESULT_W-1:0] bin_total_o,
  output logic [RESULT_W-1:0] below_total_o,
  output logic [RESULT_W-1:0] above_total_o,
  output logic [CLASS_W-1:0]  sample_class_o,
  output logic [SEL_W-1:0]    sample_bin_o
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  hbo_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hbo_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  hbo_datapath #(
    .MAX_BINS    (MAX_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .status_o       (status),
    .kind_i         (kind_i),
    .sample_i       (sample_i),
    .bin_select_i   (bin_select_i),
    .valid_o        (valid_o),
    .bin_total_o    (bin_total_o),
    .below_total_o  (below_total_o),
    .above_total_o  (above_total_o),
    .sample_class_o (sample_class_o),
    .sample_bin_o   (sample_bin_o)
  );

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !valid_o)
    else $error("accepted request did not raise busy");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result shown while still busy");

endmodule
